FILE: rtl/ps_comp_pkg.sv
`default_nettype none
package ps_comp_pkg;

  typedef enum logic [2:0] {
    IDX_PRESSURE_SENSITIVITY = 3'd0,
    IDX_PRESSURE_OFFSET      = 3'd1,
    IDX_SENS_TEMP_COEF       = 3'd2,
    IDX_OFFSET_TEMP_COEF     = 3'd3,
    IDX_REFERENCE_TEMP       = 3'd4,
    IDX_TEMP_COEF            = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] pressure_sensitivity;
    logic [15:0] pressure_offset;
    logic [15:0] sens_temp_coef;
    logic [15:0] offset_temp_coef;
    logic [15:0] reference_temp;
    logic [15:0] temp_coef;
  } cal_t;

  typedef struct packed {
    logic [23:0] pressure_raw;
    logic [23:0] temperature_raw;
  } req_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic signed [31:0] pressure_tenth_mbar;
  } rsp_t;

  // first-order results
  typedef struct packed {
    logic        [23:0] d1;
    logic signed [19:0] temp;
    logic signed [35:0] off;
    logic signed [34:0] sens;
    logic        [16:0] ti_lo;
    logic        [12:0] ti_hi;
  } fo_t;

  // second-order corrected terms
  typedef struct packed {
    logic        [23:0] d1;
    logic signed [20:0] temp2;
    logic signed [41:0] off2;
    logic signed [40:0] sens2;
  } so_t;

endpackage
`default_nettype wire

FILE: rtl/ps_comp_first.sv
`default_nettype none
module ps_comp_first (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire ps_comp_pkg::cal_t  cal_i,
  input  wire                     in_valid_i,
  output logic                    in_ready_o,
  input  wire ps_comp_pkg::req_t  in_data_i,
  output logic                    out_valid_o,
  input  wire                     out_ready_i,
  output ps_comp_pkg::fo_t        out_data_o
);

  localparam int NumStages = 3;
  localparam logic signed [41:0] Rnd23 = 42'sd8388607;
  localparam logic signed [41:0] Rnd8  = 42'sd255;
  localparam logic signed [41:0] Rnd7  = 42'sd127;
  localparam logic signed [19:0] TempRef = 20'sd2000;

  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] en;

  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
    end
  end

  // stage 1: dT
  logic        [23:0] s1_d1_q;
  logic signed [24:0] s1_dt_q, s1_dt_d;

  always_comb begin
    s1_dt_d = $signed({1'b0, in_data_i.temperature_raw})
            - $signed({1'b0, cal_i.reference_temp, 8'h00});
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_d1_q <= in_data_i.pressure_raw;
      s1_dt_q <= s1_dt_d;
    end
  end

  // stage 2: products of dT
  logic        [23:0] s2_d1_q;
  logic signed [41:0] s2_p6_q, s2_p6_d;
  logic signed [41:0] s2_p4_q, s2_p4_d;
  logic signed [41:0] s2_p3_q, s2_p3_d;
  logic signed [49:0] dtsq_full;
  logic        [48:0] s2_dtsq_q;

  always_comb begin
    s2_p6_d   = s1_dt_q * $signed({1'b0, cal_i.temp_coef});
    s2_p4_d   = s1_dt_q * $signed({1'b0, cal_i.offset_temp_coef});
    s2_p3_d   = s1_dt_q * $signed({1'b0, cal_i.sens_temp_coef});
    dtsq_full = s1_dt_q * s1_dt_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_d1_q   <= s1_d1_q;
      s2_p6_q   <= s2_p6_d;
      s2_p4_q   <= s2_p4_d;
      s2_p3_q   <= s2_p3_d;
      s2_dtsq_q <= dtsq_full[48:0];
    end
  end

  // stage 3: TEMP, OFF, SENS, Ti candidates (divides truncate toward zero)
  logic signed [41:0] p6_adj, p4_adj, p3_adj;
  logic signed [41:0] q6, q4, q3;
  logic        [49:0] t3;
  ps_comp_pkg::fo_t   s3_q, s3_d;

  always_comb begin
    p6_adj = s2_p6_q + (s2_p6_q[41] ? Rnd23 : 42'sd0);
    p4_adj = s2_p4_q + (s2_p4_q[41] ? Rnd7 : 42'sd0);
    p3_adj = s2_p3_q + (s2_p3_q[41] ? Rnd8 : 42'sd0);
    q6 = p6_adj >>> 23;
    q4 = p4_adj >>> 7;
    q3 = p3_adj >>> 8;
    t3 = {1'b0, s2_dtsq_q} + {s2_dtsq_q, 1'b0};
    s3_d.d1    = s2_d1_q;
    s3_d.temp  = q6[19:0] + TempRef;
    s3_d.off   = {4'b0, cal_i.pressure_offset, 16'h0000} + q4[35:0];
    s3_d.sens  = {4'b0, cal_i.pressure_sensitivity, 15'h0000} + q3[34:0];
    s3_d.ti_lo = t3[49:33];
    s3_d.ti_hi = s2_dtsq_q[48:36];
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_q <= s3_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NumStages-1];
  assign out_data_o  = s3_q;

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en[0] |-> (&v_q) && !out_ready_i)
    else $error("first-order stage stalls while not full");

endmodule
`default_nettype wire

FILE: rtl/ps_comp_second.sv
`default_nettype none
module ps_comp_second (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_ready_o,
  input  wire ps_comp_pkg::fo_t   in_data_i,
  output logic                    out_valid_o,
  input  wire                     out_ready_i,
  output ps_comp_pkg::so_t        out_data_o
);

  localparam int NumStages = 2;
  localparam logic signed [20:0] TempRef  = 21'sd2000;
  localparam logic signed [20:0] TempVlow = -21'sd1500;

  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] en;

  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
    end
  end

  // stage 1: range flags, squares, TEMP2
  logic signed [20:0] temp_x, dtemp, tlow;
  logic signed [41:0] dsq_full, lsq_full;
  logic        [16:0] ti;
  logic               s1_lt_q, s1_lt_d;
  logic               s1_vlt_q, s1_vlt_d;
  logic        [35:0] s1_dsq_q, s1_lsq_q;
  logic signed [20:0] s1_temp2_q, s1_temp2_d;
  logic        [23:0] s1_d1_q;
  logic signed [35:0] s1_off_q;
  logic signed [34:0] s1_sens_q;

  always_comb begin
    temp_x     = 21'(in_data_i.temp);
    s1_lt_d    = temp_x < TempRef;
    s1_vlt_d   = temp_x < TempVlow;
    dtemp      = temp_x - TempRef;
    tlow       = temp_x - TempVlow;
    dsq_full   = dtemp * dtemp;
    lsq_full   = tlow * tlow;
    ti         = s1_lt_d ? in_data_i.ti_lo : {4'b0, in_data_i.ti_hi};
    s1_temp2_d = temp_x - $signed({4'b0, ti});
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_lt_q    <= s1_lt_d;
      s1_vlt_q   <= s1_vlt_d;
      s1_dsq_q   <= dsq_full[35:0];
      s1_lsq_q   <= lsq_full[35:0];
      s1_temp2_q <= s1_temp2_d;
      s1_d1_q    <= in_data_i.d1;
      s1_off_q   <= in_data_i.off;
      s1_sens_q  <= in_data_i.sens;
    end
  end

  // stage 2: OFFi, SENSi and the corrected OFF, SENS
  logic [37:0] off_a, sens_a;
  logic [38:0] off_v;
  logic [37:0] sens_v;
  logic [40:0] off_i;
  logic [39:0] sens_i;
  ps_comp_pkg::so_t s2_q, s2_d;

  always_comb begin
    off_a  = {2'b0, s1_dsq_q} + {1'b0, s1_dsq_q, 1'b0};
    sens_a = {2'b0, s1_dsq_q} + {s1_dsq_q, 2'b0};
    off_v  = {s1_lsq_q, 3'b0} - {3'b0, s1_lsq_q};
    sens_v = {s1_lsq_q, 2'b0};
    if (s1_lt_q) begin
      off_i  = 41'(off_a[37:1]) + (s1_vlt_q ? 41'(off_v) : 41'd0);
      sens_i = 40'(sens_a[37:3]) + (s1_vlt_q ? 40'(sens_v) : 40'd0);
    end else begin
      off_i  = 41'(s1_dsq_q[35:4]);
      sens_i = '0;
    end
    s2_d.d1    = s1_d1_q;
    s2_d.temp2 = s1_temp2_q;
    s2_d.off2  = 42'(s1_off_q) - $signed({1'b0, off_i});
    s2_d.sens2 = 41'(s1_sens_q) - $signed({1'b0, sens_i});
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_q <= s2_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NumStages-1];
  assign out_data_o  = s2_q;

  a_vlow_implies_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] && s1_vlt_q |-> s1_lt_q)
    else $error("very-low temperature flag without low temperature flag");

endmodule
`default_nettype wire

FILE: rtl/ps_comp_press.sv
`default_nettype none
module ps_comp_press (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_ready_o,
  input  wire ps_comp_pkg::so_t   in_data_i,
  output logic                    out_valid_o,
  input  wire                     out_ready_i,
  output ps_comp_pkg::rsp_t       out_data_o
);

  localparam int NumStages = 5;
  localparam logic [63:0] Rnd21 = 64'd2097151;
  localparam logic [43:0] Rnd13 = 44'd8191;

  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] en;

  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage 1: D1 * SENS2 as two partial products
  logic        [44:0] s1_pl_q, s1_pl_d;
  logic signed [44:0] s1_ph_q, s1_ph_d;
  logic signed [41:0] s1_off2_q;
  logic signed [20:0] s1_temp2_q;

  always_comb begin
    s1_pl_d = in_data_i.d1 * in_data_i.sens2[20:0];
    s1_ph_d = $signed({1'b0, in_data_i.d1}) * $signed(in_data_i.sens2[40:21]);
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_pl_q    <= s1_pl_d;
      s1_ph_q    <= s1_ph_d;
      s1_off2_q  <= in_data_i.off2;
      s1_temp2_q <= in_data_i.temp2;
    end
  end

  // stage 2: combine partial products
  logic        [63:0] s2_sum_q, s2_sum_d;
  logic signed [41:0] s2_off2_q;
  logic signed [20:0] s2_temp2_q;

  always_comb begin
    s2_sum_d = {s1_ph_q[42:0], 21'b0} + {19'b0, s1_pl_q};
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_sum_q   <= s2_sum_d;
      s2_off2_q  <= s1_off2_q;
      s2_temp2_q <= s1_temp2_q;
    end
  end

  // stage 3: divide by 2^21 toward zero
  logic        [63:0] sum_adj;
  logic signed [42:0] s3_q_q;
  logic signed [41:0] s3_off2_q;
  logic signed [20:0] s3_temp2_q;

  always_comb begin
    sum_adj = s2_sum_q + (s2_sum_q[63] ? Rnd21 : 64'd0);
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_q_q     <= sum_adj[63:21];
      s3_off2_q  <= s2_off2_q;
      s3_temp2_q <= s2_temp2_q;
    end
  end

  // stage 4: subtract OFF2
  logic signed [43:0] s4_r_q, s4_r_d;
  logic signed [20:0] s4_temp2_q;

  always_comb begin
    s4_r_d = 44'(s3_q_q) - 44'(s3_off2_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s4_r_q     <= s4_r_d;
      s4_temp2_q <= s3_temp2_q;
    end
  end

  // stage 5: divide by 2^13 toward zero, output register
  logic [43:0]       r_adj;
  ps_comp_pkg::rsp_t s5_q, s5_d;

  always_comb begin
    r_adj = s4_r_q + (s4_r_q[43] ? Rnd13 : 44'd0);
    s5_d.temperature_centi   = 32'(s4_temp2_q);
    s5_d.pressure_tenth_mbar = {r_adj[43], r_adj[43:13]};
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s5_q <= s5_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NumStages-1];
  assign out_data_o  = s5_q;

  a_held_not_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] && !en[1] |=> v_q[0])
    else $error("held request dropped in pressure stage");

endmodule
`default_nettype wire

FILE: rtl/pressure_sensor_compensation_top.sv
// A request passes through 10 register stages: 3 first-order, 2 second-order and
// 5 pressure. Throughput: one request per cycle while the output is not stalled;
// stages advance independently, so bubbles are squeezed out and a stall at the output
// only stops the input once all 10 stages are full.
// Reset (rst_ni low, async) clears all stage valid bits and the six calibration words.
`default_nettype none
module pressure_sensor_compensation_top (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_stall_o,
  input  wire ps_comp_pkg::req_t  in_data_i,
  output logic                    out_valid_o,
  input  wire                     out_stall_i,
  output ps_comp_pkg::rsp_t       out_data_o,
  input  wire                     cfg_we_i,
  input  wire [2:0]               cfg_idx_i,
  input  wire [15:0]              cfg_data_i
);

  ps_comp_pkg::cal_t cal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ps_comp_pkg::IDX_PRESSURE_SENSITIVITY: cal_q.pressure_sensitivity <= cfg_data_i;
        ps_comp_pkg::IDX_PRESSURE_OFFSET:      cal_q.pressure_offset      <= cfg_data_i;
        ps_comp_pkg::IDX_SENS_TEMP_COEF:       cal_q.sens_temp_coef       <= cfg_data_i;
        ps_comp_pkg::IDX_OFFSET_TEMP_COEF:     cal_q.offset_temp_coef     <= cfg_data_i;
        ps_comp_pkg::IDX_REFERENCE_TEMP:       cal_q.reference_temp       <= cfg_data_i;
        ps_comp_pkg::IDX_TEMP_COEF:            cal_q.temp_coef            <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic             first_ready, first_valid;
  ps_comp_pkg::fo_t first_data;
  logic             second_ready, second_valid;
  ps_comp_pkg::so_t second_data;
  logic             press_ready;

  ps_comp_first u_first (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cal_i       (cal_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (first_ready),
    .in_data_i   (in_data_i),
    .out_valid_o (first_valid),
    .out_ready_i (second_ready),
    .out_data_o  (first_data)
  );

  ps_comp_second u_second (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (first_valid),
    .in_ready_o  (second_ready),
    .in_data_i   (first_data),
    .out_valid_o (second_valid),
    .out_ready_i (press_ready),
    .out_data_o  (second_data)
  );

  ps_comp_press u_press (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (second_valid),
    .in_ready_o  (press_ready),
    .in_data_i   (second_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (!out_stall_i),
    .out_data_o  (out_data_o)
  );

  assign in_stall_o = !first_ready;

  a_stall_needs_out_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result at the output");

  a_ref_temp_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_idx_i == ps_comp_pkg::IDX_REFERENCE_TEMP
      |=> cal_q.reference_temp == $past(cfg_data_i))
    else $error("reference temperature write not taken");

  a_unknown_idx_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_idx_i > ps_comp_pkg::IDX_TEMP_COEF |=> $stable(cal_q))
    else $error("write to unknown register index changed calibration");

endmodule
`default_nettype wire
